### hw/rtl/tctt_pkg.sv
// Package for the tiled corner-turn transpose core.
// Holds status codes, register indexes, field widths and reset values.
// No dependencies.
package tctt_pkg;

  localparam int STATUS_W   = 2;
  localparam int ADDR_W     = 26;
  localparam int SAMPLE_W   = 32;
  localparam int CFG_DATA_W = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int TILE_CFG_W = 7;

  localparam logic [STATUS_W-1:0] ST_STORED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMITTED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE  = 2'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam int ROWS_RST = 8192;
  localparam int COLS_RST = 8192;
  localparam int TILE_RST = 64;

endpackage

### hw/rtl/tctt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used as the tile buffer of the transpose core. No dependencies.
module tctt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/tiled_corner_turn_transpose_core.sv
// Tiled corner-turn transpose core: top level.
// Depends on tctt_pkg and tctt_ram.
//
// Walks a frame_rows x frame_cols frame in square tiles (row tiles outer,
// column tiles inner, edge tiles clipped). A load item (tuser 0) stores one
// sample and returns its source index; once the tile is full, drain items
// (tuser 1) return samples column by column with their destination index.
// Loads into a full tile and drains from a non-full tile are rejected.
// One item is accepted per cycle unless the output stalls; each item passes stage one,
// alongside the registered tile RAM read, then the address multiplier into the result
// register. The tile RAM needs no clearing after reset. A rows, cols or tile size
// write restarts the walk; any config write must be issued while the core is idle.
module tiled_corner_turn_transpose_core #(
  parameter int TILE_MAX  = 64,
  parameter int FRAME_MAX = 8192
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [31:0]                       in_tdata,   // sample[31:0]
  input  logic [0:0]                        in_tuser,   // op[0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [63:0]                       out_tdata,  // address[25:0], data_out[57:26]
  output logic [2:0]                        out_tuser,  // status[1:0], last_in_tile[2]
  output logic                              out_tlast,  // last_in_frame
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tctt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tctt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int RW    = $clog2(FRAME_MAX + 1);
  localparam int TW    = $clog2(TILE_MAX + 1);
  localparam int CW    = $clog2(TILE_MAX);
  localparam int DEPTH = TILE_MAX * TILE_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = 2 * RW;
  localparam int SW    = (PW + 1 > tctt_pkg::ADDR_W) ? PW + 1 : tctt_pkg::ADDR_W;
  localparam int ROWS_INIT = (tctt_pkg::ROWS_RST > FRAME_MAX) ? FRAME_MAX : tctt_pkg::ROWS_RST;
  localparam int COLS_INIT = (tctt_pkg::COLS_RST > FRAME_MAX) ? FRAME_MAX : tctt_pkg::COLS_RST;
  localparam int TILE_INIT = (tctt_pkg::TILE_RST > TILE_MAX) ? TILE_MAX : tctt_pkg::TILE_RST;
  localparam int TH_INIT   = (ROWS_INIT > TILE_INIT) ? TILE_INIT : ROWS_INIT;
  localparam int TWD_INIT  = (COLS_INIT > TILE_INIT) ? TILE_INIT : COLS_INIT;

  function automatic logic [RW-1:0] clamp_dim(input logic [tctt_pkg::CFG_DATA_W-1:0] v);
    logic [RW-1:0] r;
    if (v == '0) begin
      r = RW'(1);
    end else if (32'(v) > FRAME_MAX) begin
      r = RW'(FRAME_MAX);
    end else begin
      r = RW'(v);
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] slot_of(input logic [CW-1:0] row, input logic [CW-1:0] col);
    return AW'(row) * AW'(TILE_MAX) + AW'(col);
  endfunction

  // frame walk state
  logic [RW-1:0] rows_r, rows_nxt, cols_r, cols_nxt;
  logic [TW-1:0] tsz_r, tsz_nxt, th_r, th_nxt, tw_r, tw_nxt;
  logic [RW-1:0] rbase_r, rbase_nxt, cbase_r, cbase_nxt;
  logic [CW-1:0] lrow_r, lrow_nxt, lcol_r, lcol_nxt;
  logic [CW-1:0] drow_r, drow_nxt, dcol_r, dcol_nxt;
  logic          full_r, full_nxt;

  // stage one
  logic                          s1_vld_r, s1_vld_nxt;
  logic [tctt_pkg::STATUS_W-1:0] s1_status_r, s1_status_nxt;
  logic [RW-1:0]                 s1_mula_r, s1_mula_nxt, s1_mulb_r, s1_mulb_nxt;
  logic [RW-1:0]                 s1_add_r, s1_add_nxt;
  logic                          s1_lit_r, s1_lit_nxt, s1_lif_r, s1_lif_nxt;

  // result register
  logic                          out_vld_r;
  logic [tctt_pkg::STATUS_W-1:0] out_status_r;
  logic [tctt_pkg::ADDR_W-1:0]   out_addr_r;
  logic [tctt_pkg::SAMPLE_W-1:0] out_data_r;
  logic                          out_lit_r, out_lif_r;

  logic          adv2, in_acc, cfg_acc, is_drain;
  logic          ld_last, dr_last, dr_col_end, ld_row_end;
  logic          last_row_tile, last_col_tile;
  logic [RW-1:0] rem_rows, rem_cols;
  logic          ram_we, ram_re;
  logic [tctt_pkg::SAMPLE_W-1:0] ram_rdata;
  logic [PW-1:0] prod;
  logic [SW-1:0] addr_sum;

  assign adv2      = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || adv2;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid;
  assign is_drain  = (in_tuser[0] == tctt_pkg::OP_DRAIN);

  assign ld_row_end = (TW'(lcol_r) + TW'(1)) == tw_r;
  assign ld_last    = ((TW'(lrow_r) + TW'(1)) == th_r) && ld_row_end;
  assign dr_col_end = (TW'(drow_r) + TW'(1)) == th_r;
  assign dr_last    = dr_col_end && ((TW'(dcol_r) + TW'(1)) == tw_r);
  assign last_row_tile = ((RW+1)'(rbase_r) + (RW+1)'(th_r)) >= (RW+1)'(rows_r);
  assign last_col_tile = ((RW+1)'(cbase_r) + (RW+1)'(tw_r)) >= (RW+1)'(cols_r);

  assign ram_we = in_acc && !is_drain && !full_r;
  assign ram_re = in_acc && is_drain && full_r;

  always_comb begin
    rows_nxt  = rows_r;
    cols_nxt  = cols_r;
    tsz_nxt   = tsz_r;
    rbase_nxt = rbase_r;
    cbase_nxt = cbase_r;
    lrow_nxt  = lrow_r;
    lcol_nxt  = lcol_r;
    drow_nxt  = drow_r;
    dcol_nxt  = dcol_r;
    full_nxt  = full_r;

    s1_vld_nxt    = s1_vld_r;
    s1_status_nxt = s1_status_r;
    s1_mula_nxt   = s1_mula_r;
    s1_mulb_nxt   = s1_mulb_r;
    s1_add_nxt    = s1_add_r;
    s1_lit_nxt    = s1_lit_r;
    s1_lif_nxt    = s1_lif_r;

    if (adv2) begin
      s1_vld_nxt = 1'b0;
    end

    if (in_acc) begin
      s1_vld_nxt    = 1'b1;
      s1_status_nxt = tctt_pkg::ST_REJECTED;
      s1_mula_nxt   = '0;
      s1_mulb_nxt   = '0;
      s1_add_nxt    = '0;
      s1_lit_nxt    = 1'b0;
      s1_lif_nxt    = 1'b0;
      if (!is_drain && !full_r) begin
        s1_status_nxt = tctt_pkg::ST_STORED;
        s1_mula_nxt   = rbase_r + RW'(lrow_r);
        s1_mulb_nxt   = cols_r;
        s1_add_nxt    = cbase_r + RW'(lcol_r);
        s1_lit_nxt    = ld_last;
        if (ld_last) begin
          full_nxt = 1'b1;
          lrow_nxt = '0;
          lcol_nxt = '0;
        end else if (ld_row_end) begin
          lcol_nxt = '0;
          lrow_nxt = lrow_r + CW'(1);
        end else begin
          lcol_nxt = lcol_r + CW'(1);
        end
      end else if (is_drain && full_r) begin
        s1_status_nxt = tctt_pkg::ST_EMITTED;
        s1_mula_nxt   = cbase_r + RW'(dcol_r);
        s1_mulb_nxt   = rows_r;
        s1_add_nxt    = rbase_r + RW'(drow_r);
        s1_lit_nxt    = dr_last;
        s1_lif_nxt    = dr_last && last_row_tile && last_col_tile;
        if (dr_last) begin
          full_nxt = 1'b0;
          drow_nxt = '0;
          dcol_nxt = '0;
          if (last_col_tile) begin
            cbase_nxt = '0;
            rbase_nxt = last_row_tile ? '0 : rbase_r + RW'(tsz_r);
          end else begin
            cbase_nxt = cbase_r + RW'(tsz_r);
          end
        end else if (dr_col_end) begin
          drow_nxt = '0;
          dcol_nxt = dcol_r + CW'(1);
        end else begin
          drow_nxt = drow_r + CW'(1);
        end
      end
    end

    if (cfg_acc && (cfg_index == tctt_pkg::REG_FRAME_ROWS ||
                    cfg_index == tctt_pkg::REG_FRAME_COLS ||
                    cfg_index == tctt_pkg::REG_TILE_SIZE)) begin
      case (cfg_index)
        tctt_pkg::REG_FRAME_ROWS: rows_nxt = clamp_dim(cfg_data);
        tctt_pkg::REG_FRAME_COLS: cols_nxt = clamp_dim(cfg_data);
        tctt_pkg::REG_TILE_SIZE: begin
          if (cfg_data[tctt_pkg::TILE_CFG_W-1:0] == '0) begin
            tsz_nxt = TW'(1);
          end else if (32'(cfg_data[tctt_pkg::TILE_CFG_W-1:0]) > TILE_MAX) begin
            tsz_nxt = TW'(TILE_MAX);
          end else begin
            tsz_nxt = TW'(cfg_data[tctt_pkg::TILE_CFG_W-1:0]);
          end
        end
        default: begin
          rows_nxt = rows_r;
        end
      endcase
      rbase_nxt = '0;
      cbase_nxt = '0;
      lrow_nxt  = '0;
      lcol_nxt  = '0;
      drow_nxt  = '0;
      dcol_nxt  = '0;
      full_nxt  = 1'b0;
    end

    // clip the next tile to the frame edge
    rem_rows = rows_nxt - rbase_nxt;
    rem_cols = cols_nxt - cbase_nxt;
    th_nxt   = ((RW+TW)'(rem_rows) > (RW+TW)'(tsz_nxt)) ? tsz_nxt : TW'(rem_rows);
    tw_nxt   = ((RW+TW)'(rem_cols) > (RW+TW)'(tsz_nxt)) ? tsz_nxt : TW'(rem_cols);
  end

  assign prod     = PW'(s1_mula_r) * PW'(s1_mulb_r);
  assign addr_sum = SW'(prod) + SW'(s1_add_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r    <= RW'(ROWS_INIT);
      cols_r    <= RW'(COLS_INIT);
      tsz_r     <= TW'(TILE_INIT);
      th_r      <= TW'(TH_INIT);
      tw_r      <= TW'(TWD_INIT);
      rbase_r   <= '0;
      cbase_r   <= '0;
      lrow_r    <= '0;
      lcol_r    <= '0;
      drow_r    <= '0;
      dcol_r    <= '0;
      full_r    <= 1'b0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      rows_r    <= rows_nxt;
      cols_r    <= cols_nxt;
      tsz_r     <= tsz_nxt;
      th_r      <= th_nxt;
      tw_r      <= tw_nxt;
      rbase_r   <= rbase_nxt;
      cbase_r   <= cbase_nxt;
      lrow_r    <= lrow_nxt;
      lcol_r    <= lcol_nxt;
      drow_r    <= drow_nxt;
      dcol_r    <= dcol_nxt;
      full_r    <= full_nxt;
      s1_vld_r  <= s1_vld_nxt;
      if (adv2) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_status_r <= s1_status_nxt;
    s1_mula_r   <= s1_mula_nxt;
    s1_mulb_r   <= s1_mulb_nxt;
    s1_add_r    <= s1_add_nxt;
    s1_lit_r    <= s1_lit_nxt;
    s1_lif_r    <= s1_lif_nxt;
    if (adv2) begin
      out_status_r <= s1_status_r;
      out_addr_r   <= addr_sum[tctt_pkg::ADDR_W-1:0];
      out_data_r   <= (s1_status_r == tctt_pkg::ST_EMITTED) ? ram_rdata : '0;
      out_lit_r    <= s1_lit_r;
      out_lif_r    <= s1_lif_r;
    end
  end

  tctt_ram #(
    .WIDTH (tctt_pkg::SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_tile_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_of(lrow_r, lcol_r)),
    .wdata (in_tdata),
    .re    (ram_re),
    .raddr (slot_of(drow_r, dcol_r)),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b0, out_data_r, out_addr_r};
  assign out_tuser  = {out_lit_r, out_status_r};
  assign out_tlast  = out_lif_r;

endmodule

### test/testbench.sv
// Self-checking testbench for tiled_corner_turn_transpose_core.
// Drives load and drain items plus register writes, predicts every result in a scoreboard.
// Depends on tctt_pkg and the core RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TILE_MAX    = 64;
  localparam int FRAME_MAX   = 8192;
  localparam int TILE_DEPTH  = TILE_MAX * TILE_MAX;
  localparam int LATENCY_PAD = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [tctt_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [tctt_pkg::STATUS_W-1:0] status;
    logic [tctt_pkg::ADDR_W-1:0]   address;
    logic [tctt_pkg::SAMPLE_W-1:0] data;
    logic                          last_tile;
    logic                          last_frame;
  } turn_result_t;

  class corner_turn_board;
    logic [tctt_pkg::SAMPLE_W-1:0]   tile_buf [0:TILE_DEPTH-1];
    logic [tctt_pkg::CFG_DATA_W-1:0] rows_reg;
    logic [tctt_pkg::CFG_DATA_W-1:0] cols_reg;
    logic [tctt_pkg::TILE_CFG_W-1:0] tile_reg;
    int unsigned                     row_base, col_base;
    int unsigned                     ld_row, ld_col, dr_row, dr_col;
    bit                              tile_full;
    turn_result_t                    due_q [$];
    int unsigned                     errors;

    function new();
      rows_reg = tctt_pkg::CFG_DATA_W'(tctt_pkg::ROWS_RST);
      cols_reg = tctt_pkg::CFG_DATA_W'(tctt_pkg::COLS_RST);
      tile_reg = tctt_pkg::TILE_CFG_W'(tctt_pkg::TILE_RST);
      errors   = 0;
      restart();
    endfunction

    function void restart();
      row_base  = 0;
      col_base  = 0;
      ld_row    = 0;
      ld_col    = 0;
      dr_row    = 0;
      dr_col    = 0;
      tile_full = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic [tctt_pkg::CFG_IDX_W-1:0] idx,
                            logic [tctt_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        tctt_pkg::REG_FRAME_ROWS: rows_reg = data;
        tctt_pkg::REG_FRAME_COLS: cols_reg = data;
        tctt_pkg::REG_TILE_SIZE:  tile_reg = data[tctt_pkg::TILE_CFG_W-1:0];
        default:                  return;
      endcase
      restart();
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void note_input(logic op, logic [tctt_pkg::SAMPLE_W-1:0] smp);
      int unsigned  nr, nc, t, th, tw, slot, addr;
      bit           last_rt, last_ct;
      turn_result_t r;
      nr = clamp(rows_reg, 1, FRAME_MAX);
      nc = clamp(cols_reg, 1, FRAME_MAX);
      t  = clamp(tile_reg, 1, TILE_MAX);
      if (row_base >= nr) row_base = 0;
      if (col_base >= nc) col_base = 0;
      th = nr - row_base;
      if (th > t) th = t;
      tw = nc - col_base;
      if (tw > t) tw = t;
      r.status     = tctt_pkg::ST_REJECTED;
      r.address    = '0;
      r.data       = '0;
      r.last_tile  = 1'b0;
      r.last_frame = 1'b0;
      if (op == tctt_pkg::OP_LOAD) begin
        if (!tile_full) begin
          if (ld_row >= th || ld_col >= tw) begin
            ld_row = 0;
            ld_col = 0;
          end
          slot = (ld_row * TILE_MAX + ld_col) % TILE_DEPTH;
          tile_buf[slot] = smp;
          addr = (row_base + ld_row) * nc + col_base + ld_col;
          r.status  = tctt_pkg::ST_STORED;
          r.address = addr[tctt_pkg::ADDR_W-1:0];
          if (ld_row == th - 1 && ld_col == tw - 1) begin
            r.last_tile = 1'b1;
            tile_full   = 1;
            ld_row      = 0;
            ld_col      = 0;
          end else begin
            ld_col++;
            if (ld_col == tw) begin
              ld_col = 0;
              ld_row++;
            end
          end
        end
      end else if (tile_full) begin
        if (dr_row >= th || dr_col >= tw) begin
          dr_row = 0;
          dr_col = 0;
        end
        slot = (dr_row * TILE_MAX + dr_col) % TILE_DEPTH;
        addr = (col_base + dr_col) * nr + row_base + dr_row;
        r.status  = tctt_pkg::ST_EMITTED;
        r.address = addr[tctt_pkg::ADDR_W-1:0];
        r.data    = tile_buf[slot];
        if (dr_row == th - 1 && dr_col == tw - 1) begin
          last_rt      = (row_base + th >= nr);
          last_ct      = (col_base + tw >= nc);
          r.last_tile  = 1'b1;
          r.last_frame = last_rt && last_ct;
          tile_full    = 0;
          dr_row       = 0;
          dr_col       = 0;
          if (last_ct) begin
            col_base = 0;
            row_base = last_rt ? 0 : row_base + t;
          end else begin
            col_base += t;
          end
        end else begin
          dr_row++;
          if (dr_row == th) begin
            dr_row = 0;
            dr_col++;
          end
        end
      end
      due_q.push_back(r);
    endfunction

    task flag(string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task check_result(logic [63:0] tdata, logic [2:0] tuser, logic tlast);
      turn_result_t e;
      if (due_q.size() == 0) begin
        flag("result with nothing outstanding");
        return;
      end
      e = due_q.pop_front();
      if (tuser[1:0] !== e.status)
        flag($sformatf("status %0d, predicted %0d", tuser[1:0], e.status));
      if (tdata[25:0] !== e.address)
        flag($sformatf("address %0d, predicted %0d", tdata[25:0], e.address));
      if (tdata[57:26] !== e.data)
        flag($sformatf("data_out %h, predicted %h", tdata[57:26], e.data));
      if (tdata[63:58] !== 6'd0)
        flag($sformatf("tdata pad bits %b not zero", tdata[63:58]));
      if (tuser[2] !== e.last_tile)
        flag($sformatf("last_in_tile %b, predicted %b", tuser[2], e.last_tile));
      if (tlast !== e.last_frame)
        flag($sformatf("last_in_frame %b, predicted %b", tlast, e.last_frame));
    endtask
  endclass

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [31:0]                     in_tdata   = '0;
  logic [0:0]                      in_tuser   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [63:0]                     out_tdata;
  logic [2:0]                      out_tuser;
  logic                            out_tlast;
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;
  logic [tctt_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [tctt_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

  int unsigned      send_gap_pct = 0;
  int unsigned      stall_pct    = 0;
  int unsigned      cycle_count  = 0;
  corner_turn_board sb           = new();

  tiled_corner_turn_transpose_core #(
    .TILE_MAX (TILE_MAX),
    .FRAME_MAX(FRAME_MAX)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_item(input logic op, input logic [31:0] smp);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= smp;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    sb.note_input(op, smp);
  endtask

  task automatic write_reg(input logic [tctt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tctt_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    sb.write_reg(idx, data);
  endtask

  task automatic set_frame(input logic [tctt_pkg::CFG_DATA_W-1:0] rows,
                           input logic [tctt_pkg::CFG_DATA_W-1:0] cols,
                           input logic [tctt_pkg::CFG_DATA_W-1:0] tile);
    write_reg(tctt_pkg::REG_FRAME_ROWS, rows);
    write_reg(tctt_pkg::REG_FRAME_COLS, cols);
    write_reg(tctt_pkg::REG_TILE_SIZE, tile);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned                     gap_tab [4];
    int unsigned                     stall_tab [4];
    int                              n;
    int unsigned                     roll;
    logic                            op;
    logic [31:0]                     smp;
    logic [tctt_pkg::CFG_DATA_W-1:0] rows, cols, tile;
    gap_tab   = '{0, 67, 0, 38};
    stall_tab = '{0, 0, 67, 38};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_gap_pct = 38;
    stall_pct    = 38;
    send_item(tctt_pkg::OP_DRAIN, 32'hFFFF_FFFF);
    send_item(tctt_pkg::OP_LOAD, 32'h0000_0000);
    send_item(tctt_pkg::OP_LOAD, 32'hFFFF_FFFF);
    send_item(tctt_pkg::OP_LOAD, 32'h8000_0001);
    wait_results();

    set_frame(14'd3, 14'd2, 14'd2);
    for (int k = 0; k < 4; k++) send_item(tctt_pkg::OP_LOAD, $urandom);
    send_item(tctt_pkg::OP_LOAD, 32'h5A5A_A5A5);
    for (int k = 0; k < 4; k++) send_item(tctt_pkg::OP_DRAIN, $urandom);
    send_item(tctt_pkg::OP_DRAIN, $urandom);
    for (int k = 0; k < 2; k++) send_item(tctt_pkg::OP_LOAD, $urandom);
    for (int k = 0; k < 2; k++) send_item(tctt_pkg::OP_DRAIN, $urandom);
    send_item(tctt_pkg::OP_LOAD, $urandom);
    wait_results();

    set_frame(14'd0, 14'd0, 14'd0);
    send_item(tctt_pkg::OP_LOAD, 32'h7FFF_FFFE);
    send_item(tctt_pkg::OP_DRAIN, 32'h0000_0000);
    send_item(tctt_pkg::OP_LOAD, 32'hC3C3_3C3C);
    send_item(tctt_pkg::OP_LOAD, 32'h1234_5678);
    wait_results();
    write_reg(REG_UNUSED, 14'h3FFF);
    cfg_valid <= 1'b0;
    send_item(tctt_pkg::OP_DRAIN, $urandom);

    for (int ph = 0; ph < 16; ph++) begin
      wait_results();
      rows = tctt_pkg::CFG_DATA_W'($urandom_range(1, 12));
      cols = tctt_pkg::CFG_DATA_W'($urandom_range(1, 12));
      tile = tctt_pkg::CFG_DATA_W'($urandom_range(1, 8));
      n    = 28;
      case (ph)
        3: begin
          rows = 14'h3FFF;
          cols = tctt_pkg::CFG_DATA_W'($urandom_range(1, 5));
          tile = 14'd0;
        end
        7: begin
          rows = 14'd1;
          cols = 14'd66;
          tile = 14'd127;
          n    = 140;
        end
        11: begin
          rows = 14'd8192;
          cols = 14'd0;
          tile = 14'h3F83;
        end
        13: begin
          rows = tctt_pkg::CFG_DATA_W'($urandom_range(1, 4));
          cols = 14'd8192;
          tile = 14'd64;
        end
        default: ;
      endcase
      set_frame(rows, cols, tile);
      send_gap_pct = gap_tab[ph % 4];
      stall_pct    = stall_tab[ph % 4];
      for (int i = 0; i < n; i++) begin
        if (ph % 3 == 1 && i == n / 2) wait_results();
        roll = $urandom_range(99);
        if (roll < 88) op = sb.tile_full ? tctt_pkg::OP_DRAIN : tctt_pkg::OP_LOAD;
        else op = sb.tile_full ? tctt_pkg::OP_LOAD : tctt_pkg::OP_DRAIN;
        roll = $urandom_range(99);
        if (roll < 5) smp = 32'h0000_0000;
        else if (roll < 10) smp = 32'hFFFF_FFFF;
        else smp = $urandom;
        send_item(op, smp);
      end
    end

    wait_results();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
